// ===== rtl/core/klt_pkg.sv =====
// ----------------------------------------------------------------------------
// klt_pkg
// Shared types, constants and helper functions of the keyword lexer.
// ----------------------------------------------------------------------------
package klt_pkg;

   // field widths
   localparam int OFFSET_BITS = 24;
   localparam int LINE_BITS   = 16;
   localparam int LEN_BITS    = 16;
   localparam int KIND_BITS   = 5;

   // scanner mode codes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_STR     = 3'd1;
   localparam logic [2:0] MODE_CHWAIT  = 3'd2;
   localparam logic [2:0] MODE_CHCLOSE = 3'd3;
   localparam logic [2:0] MODE_IDENT   = 3'd4;
   localparam logic [2:0] MODE_NUM     = 3'd5;

   // request operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_EOF     = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_STRING  = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_CHAR    = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_KW_BASE = 5'd17;

   // characters with a special meaning
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;

   // one-character symbols, kind is index plus one
   localparam int NUM_SYM = 12;
   localparam logic [7:0] SYM_CHARS [NUM_SYM] = '{
      ";", "=", "+", "-", "<", "{", "}", "(", ")", "[", "]", ","
   };

   // keywords, left aligned and zero padded to eight bytes
   localparam int NUM_KW = 14;
   localparam logic [NUM_KW-1:0] KW_ALL = '1;
   localparam logic [63:0] KW_TEXT [NUM_KW] = '{
      "programa",
      {"fin", 40'h0},
      {"funcion", 8'h0},
      "retornar",
      {"si", 48'h0},
      "entonces",
      "mientras",
      {"hacer", 24'h0},
      "escribir",
      {"para", 32'h0},
      {"entero", 16'h0},
      {"char", 32'h0},
      {"cadena", 16'h0},
      {"lista", 24'h0}
   };
   localparam logic [3:0] KW_LEN [NUM_KW] = '{
      4'd8, 4'd3, 4'd7, 4'd8, 4'd2, 4'd8, 4'd8, 4'd5, 4'd8, 4'd4, 4'd6, 4'd4, 4'd6, 4'd5
   };

   // token descriptor
   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [LINE_BITS-1:0]   line;
      logic [OFFSET_BITS-1:0] start;
      logic [LEN_BITS-1:0]    length;
   } token_type;

   // tokens caused by one request, one or two
   typedef struct packed {
      logic      two;
      token_type tok0;
      token_type tok1;
   } pair_type;

   // queue slot as seen at the write and read sides
   typedef struct packed {
      logic     valid;
      pair_type pair;
   } slot_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // saturating increments
   function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [LINE_BITS-1:0] sat_line(input logic [LINE_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [LEN_BITS-1:0] sat_len(input logic [LEN_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // keywords still matching character c at position pos
   function automatic logic [NUM_KW-1:0] kw_feed(input logic [7:0] c,
                                                 input logic [LEN_BITS-1:0] pos);
      logic [NUM_KW-1:0] hit;
      hit = '0;
      for (int k = 0; k < NUM_KW; k++) begin
         hit[k] = (pos < LEN_BITS'(KW_LEN[k])) &&
                  (KW_TEXT[k][8 * (7 - int'(pos[2:0])) +: 8] == c);
      end
      return hit;
   endfunction

   // lowest alive keyword of matching length, else plain identifier
   function automatic logic [KIND_BITS-1:0] ident_kind(input logic [NUM_KW-1:0] alive,
                                                       input logic [LEN_BITS-1:0] len);
      logic [KIND_BITS-1:0] kind;
      kind = KIND_IDENT;
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         if (alive[k] && (len == LEN_BITS'(KW_LEN[k]))) begin
            kind = KIND_KW_BASE + KIND_BITS'(k);
         end
      end
      return kind;
   endfunction

endpackage

// ===== rtl/core/klt_if.sv =====
// ----------------------------------------------------------------------------
// klt_if
// Valid/ready channels of the keyword lexer: source requests and tokens.
// ----------------------------------------------------------------------------
interface klt_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] source_byte;

   modport source (output valid, output op, output source_byte, input ready);
   modport sink   (input valid, input op, input source_byte, output ready);
endinterface

interface klt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [klt_pkg::KIND_BITS-1:0]     token_kind;
   logic [klt_pkg::LINE_BITS-1:0]     token_line;
   logic [klt_pkg::OFFSET_BITS-1:0]   token_start;
   logic [klt_pkg::LEN_BITS-1:0]      token_length;
   logic                              run_last;

   modport source (output valid, output token_kind, output token_line, output token_start,
                   output token_length, output run_last, input ready);
   modport sink   (input valid, input token_kind, input token_line, input token_start,
                   input token_length, input run_last, output ready);
endinterface

// ===== rtl/core/klt_front.sv =====
// ----------------------------------------------------------------------------
// klt_front
// Scanner: takes one source byte per cycle while the queue has room, tracks
// mode, line and offset, and queues the one or two tokens a byte closes.
// ----------------------------------------------------------------------------
module klt_front (
   input  logic              clock,
   input  logic              reset,
   klt_req_if.sink           req,
   input  logic              q_ready,
   output klt_pkg::slot_type q_push
);

   logic [2:0]                        mode_ff, mode_in;
   logic [klt_pkg::LINE_BITS-1:0]     line_ff, line_in;
   logic [klt_pkg::OFFSET_BITS-1:0]   off_ff, off_in;
   logic [klt_pkg::OFFSET_BITS-1:0]   pstart_ff, pstart_in;
   logic [klt_pkg::LEN_BITS-1:0]      plen_ff, plen_in;
   logic [klt_pkg::LINE_BITS-1:0]     pline_ff, pline_in;
   logic [klt_pkg::NUM_KW-1:0]        alive_ff, alive_in;

   logic                              accept;
   logic [7:0]                        c;
   logic                              is_alpha, is_digit, is_ws, sym_hit;
   logic [klt_pkg::KIND_BITS-1:0]     sym_kind;
   logic                              pend_v, sec_v, do_idle;
   klt_pkg::token_type                pend_tok, sec_tok;

   assign req.ready = q_ready;
   assign accept    = req.valid && q_ready;
   assign c         = req.source_byte;

   // byte classes
   always_comb begin
      is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
      is_digit = (c >= "0") && (c <= "9");
      is_ws    = (c == klt_pkg::CH_SPACE) ||
                 ((c >= klt_pkg::CH_TAB) && (c <= klt_pkg::CH_CR));
      sym_hit  = 1'b0;
      sym_kind = klt_pkg::KIND_EOF;
      for (int s = 0; s < klt_pkg::NUM_SYM; s++) begin
         if (c == klt_pkg::SYM_CHARS[s]) begin
            sym_hit  = 1'b1;
            sym_kind = klt_pkg::KIND_BITS'(s + 1);
         end
      end
   end

   // next scanner state and emitted tokens
   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      off_in    = off_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      pline_in  = pline_ff;
      alive_in  = alive_ff;
      pend_v    = 1'b0;
      sec_v     = 1'b0;
      do_idle   = 1'b0;
      pend_tok  = '{kind: klt_pkg::KIND_STRING, line: pline_ff, start: pstart_ff,
                    length: plen_ff};
      sec_tok   = '{kind: klt_pkg::KIND_EOF, line: line_ff, start: off_ff, length: '0};

      if (req.op == klt_pkg::OP_END) begin
         // flush the pending lexeme, then end of source and back to reset
         unique case (mode_ff)
            klt_pkg::MODE_STR: begin
               pend_v = 1'b1;
            end
            klt_pkg::MODE_CHWAIT: begin
               pend_v          = 1'b1;
               pend_tok.kind   = klt_pkg::KIND_CHAR;
               pend_tok.length = '0;
            end
            klt_pkg::MODE_CHCLOSE: begin
               pend_v        = 1'b1;
               pend_tok.kind = klt_pkg::KIND_CHAR;
            end
            klt_pkg::MODE_IDENT: begin
               pend_v        = 1'b1;
               pend_tok.kind = klt_pkg::ident_kind(alive_ff, plen_ff);
            end
            klt_pkg::MODE_NUM: begin
               pend_v        = 1'b1;
               pend_tok.kind = klt_pkg::KIND_NUMBER;
            end
            default: begin
               pend_v = 1'b0;
            end
         endcase
         sec_v     = 1'b1;
         mode_in   = klt_pkg::MODE_IDLE;
         line_in   = klt_pkg::LINE_BITS'(1);
         off_in    = '0;
         pstart_in = '0;
         plen_in   = '0;
         pline_in  = klt_pkg::LINE_BITS'(1);
         alive_in  = klt_pkg::KW_ALL;
      end else begin
         unique case (mode_ff)
            klt_pkg::MODE_STR: begin
               if (c == klt_pkg::CH_DQUOTE) begin
                  pend_v  = 1'b1;
                  mode_in = klt_pkg::MODE_IDLE;
               end else begin
                  plen_in = klt_pkg::sat_len(plen_ff);
               end
            end
            klt_pkg::MODE_CHWAIT: begin
               pstart_in = off_ff;
               plen_in   = klt_pkg::LEN_BITS'(1);
               mode_in   = klt_pkg::MODE_CHCLOSE;
            end
            klt_pkg::MODE_CHCLOSE: begin
               pend_v        = 1'b1;
               pend_tok.kind = klt_pkg::KIND_CHAR;
               mode_in       = klt_pkg::MODE_IDLE;
               do_idle       = (c != klt_pkg::CH_SQUOTE);
            end
            klt_pkg::MODE_IDENT: begin
               if (is_alpha || is_digit) begin
                  alive_in = alive_ff & klt_pkg::kw_feed(c, plen_ff);
                  plen_in  = klt_pkg::sat_len(plen_ff);
               end else begin
                  pend_v        = 1'b1;
                  pend_tok.kind = klt_pkg::ident_kind(alive_ff, plen_ff);
                  do_idle       = 1'b1;
               end
            end
            klt_pkg::MODE_NUM: begin
               if (is_digit) begin
                  plen_in = klt_pkg::sat_len(plen_ff);
               end else begin
                  pend_v        = 1'b1;
                  pend_tok.kind = klt_pkg::KIND_NUMBER;
                  do_idle       = 1'b1;
               end
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         // byte seen from idle: whitespace, symbol or start of a lexeme
         if (do_idle) begin
            mode_in = klt_pkg::MODE_IDLE;
            if (is_ws) begin
               if (c == klt_pkg::CH_NEWLINE) begin
                  line_in = klt_pkg::sat_line(line_ff);
               end
            end else if (sym_hit) begin
               sec_v   = 1'b1;
               sec_tok = '{kind: sym_kind, line: line_ff, start: off_ff,
                           length: klt_pkg::LEN_BITS'(1)};
            end else begin
               pline_in = line_ff;
               if (c == klt_pkg::CH_DQUOTE) begin
                  mode_in   = klt_pkg::MODE_STR;
                  pstart_in = klt_pkg::sat_off(off_ff);
                  plen_in   = '0;
               end else if (c == klt_pkg::CH_SQUOTE) begin
                  mode_in   = klt_pkg::MODE_CHWAIT;
                  pstart_in = klt_pkg::sat_off(off_ff);
                  plen_in   = '0;
               end else if (is_alpha) begin
                  mode_in   = klt_pkg::MODE_IDENT;
                  pstart_in = off_ff;
                  alive_in  = klt_pkg::kw_feed(c, '0);
                  plen_in   = klt_pkg::LEN_BITS'(1);
               end else if (is_digit) begin
                  mode_in   = klt_pkg::MODE_NUM;
                  pstart_in = off_ff;
                  plen_in   = klt_pkg::LEN_BITS'(1);
               end
            end
         end
         off_in = klt_pkg::sat_off(off_ff);
      end
   end

   // pack tokens in emission order
   always_comb begin
      q_push.valid = accept && (pend_v || sec_v);
      if (pend_v) begin
         q_push.pair.two  = sec_v;
         q_push.pair.tok0 = pend_tok;
         q_push.pair.tok1 = sec_tok;
      end else begin
         q_push.pair.two  = 1'b0;
         q_push.pair.tok0 = sec_tok;
         q_push.pair.tok1 = sec_tok;
      end
   end

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= klt_pkg::MODE_IDLE;
         line_ff   <= klt_pkg::LINE_BITS'(1);
         off_ff    <= '0;
         pstart_ff <= '0;
         plen_ff   <= '0;
         pline_ff  <= klt_pkg::LINE_BITS'(1);
         alive_ff  <= klt_pkg::KW_ALL;
      end else if (accept) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         off_ff    <= off_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
         pline_ff  <= pline_in;
         alive_ff  <= alive_in;
      end
   end

endmodule

// ===== rtl/core/klt_queue.sv =====
// ----------------------------------------------------------------------------
// klt_queue
// Short first-in first-out queue of token pairs between scanner and output.
// ----------------------------------------------------------------------------
module klt_queue (
   input  logic              clock,
   input  logic              reset,
   input  klt_pkg::slot_type push,
   output logic              ready,
   input  logic              pop,
   output klt_pkg::slot_type head
);

   klt_pkg::pair_type                 store_ff [klt_pkg::QUEUE_DEPTH];
   logic [klt_pkg::QPTR_BITS-1:0]     wr_ff, wr_in;
   logic [klt_pkg::QPTR_BITS-1:0]     rd_ff, rd_in;
   logic [klt_pkg::QPTR_BITS:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   assign ready      = (count_ff != (klt_pkg::QPTR_BITS + 1)'(klt_pkg::QUEUE_DEPTH));
   assign do_push    = push.valid && ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.pair  = store_ff[rd_ff];

   // pointer and fill update
   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop  ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push.pair;
      end
   end

endmodule

// ===== rtl/core/klt_back.sv =====
// ----------------------------------------------------------------------------
// klt_back
// Output stage: splits each queued pair into single tokens, marks the last
// token of each request and holds it in a register until taken.
// ----------------------------------------------------------------------------
module klt_back (
   input  logic              clock,
   input  logic              reset,
   input  klt_pkg::slot_type head,
   output logic              pop,
   klt_rsp_if.source         rsp
);

   logic               valid_ff, valid_in;
   logic               sel_ff, sel_in;
   klt_pkg::token_type tok_ff, tok_in;
   logic               last_ff, last_in;
   logic               load;

   assign load = head.valid && (!valid_ff || rsp.ready);

   // choose next token from the head pair
   always_comb begin
      valid_in = valid_ff && !rsp.ready;
      sel_in   = sel_ff;
      tok_in   = tok_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (!sel_ff) begin
            tok_in  = head.pair.tok0;
            last_in = !head.pair.two;
            sel_in  = head.pair.two;
            pop     = !head.pair.two;
         end else begin
            tok_in  = head.pair.tok1;
            last_in = 1'b1;
            sel_in  = 1'b0;
            pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      last_ff <= last_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.token_kind   = tok_ff.kind;
   assign rsp.token_line   = tok_ff.line;
   assign rsp.token_start  = tok_ff.start;
   assign rsp.token_length = tok_ff.length;
   assign rsp.run_last     = last_ff;

endmodule

// ===== rtl/core/keyword_lexer_tokenizer.sv =====
// ----------------------------------------------------------------------------
// keyword_lexer_tokenizer
// Streaming lexer: source bytes in, token descriptors out.
// ----------------------------------------------------------------------------
// One source byte or end marker is taken per cycle as long as the four-entry
// token queue has room; the scanner mode is held in a register. A request
// closes one or two tokens (lexeme followed by a symbol, or a pending lexeme
// followed by eof), sent one at a time, so sustained output is one token per
// cycle while the receiver is ready, set by the output register. A token
// passes through the token queue and the output register before it appears
// on the response channel. No clearing pass is needed after reset.
module keyword_lexer_tokenizer (
   input  logic      clock,
   input  logic      reset,
   klt_req_if.sink   req_if,
   klt_rsp_if.source rsp_if
);

   klt_pkg::slot_type q_push;
   klt_pkg::slot_type q_head;
   logic              q_ready;
   logic              q_pop;

   // scanner
   klt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .q_ready (q_ready),
      .q_push  (q_push)
   );

   // token queue
   klt_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .ready (q_ready),
      .pop   (q_pop),
      .head  (q_head)
   );

   // output stage
   klt_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (q_head),
      .pop   (q_pop),
      .rsp   (rsp_if)
   );

   // end of source is always the last token of its request
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.token_kind == klt_pkg::KIND_EOF) |-> rsp_if.run_last)
      else $error("eof token not marked last");

   // end of source carries no length
   a_eof_len: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.token_kind == klt_pkg::KIND_EOF) |-> rsp_if.token_length == '0)
      else $error("eof token with nonzero length");

   // an accepted end marker always leaves work in the queue
   a_end_queued: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && (req_if.op == klt_pkg::OP_END) |=> q_head.valid)
      else $error("end request produced no queued tokens");

   // nothing is shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid after reset");

endmodule
